// File: hw/rtl/priority_wait_counting_semaphore_assert.svh
// Assertion macros for the priority wait counting semaphore.
`ifndef PRIORITY_WAIT_COUNTING_SEMAPHORE_ASSERT_SVH
`define PRIORITY_WAIT_COUNTING_SEMAPHORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PWCS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define PWCS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/pwcs_pkg.sv
// Shared types and constants for the priority wait counting semaphore.
package pwcs_pkg;

  localparam int CNT_W     = 8;
  localparam int ID_W      = 4;
  localparam int IN_PRIO_W = 8;
  localparam int STAT_W    = 3;
  localparam int WAIT_W    = 5;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic OP_WAIT   = 1'b0;
  localparam logic OP_SIGNAL = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    STAT_GRANTED     = 3'd0,
    STAT_BLOCKED     = 3'd1,
    STAT_WOKEN       = 3'd2,
    STAT_INCREMENTED = 3'd3,
    STAT_QUEUE_FULL  = 3'd4,
    STAT_SATURATED   = 3'd5
  } status_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;  // latch the incoming request
    logic commit;   // apply the request and load the result register
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free; // result register empty or being drained this cycle
  } dp_stat_t;

endpackage

// File: hw/rtl/pwcs_in_if.sv
// Request channel: valid/ready handshake with the semaphore request payload.
interface pwcs_in_if;
  logic                            valid;
  logic                            ready;
  logic                            op;
  logic [pwcs_pkg::ID_W-1:0]       task_id;
  logic [pwcs_pkg::IN_PRIO_W-1:0]  priority_req;

  modport source(output valid, op, task_id, priority_req, input ready);
  modport sink(input valid, op, task_id, priority_req, output ready);
endinterface

// File: hw/rtl/pwcs_out_if.sv
// Result channel: valid/ready handshake with the semaphore result payload.
interface pwcs_out_if;
  logic                          valid;
  logic                          ready;
  logic [pwcs_pkg::STAT_W-1:0]   status;
  logic [pwcs_pkg::ID_W-1:0]     woken_task;
  logic [pwcs_pkg::CNT_W-1:0]    count_now;
  logic [pwcs_pkg::WAIT_W-1:0]   waiters_now;

  modport source(output valid, status, woken_task, count_now, waiters_now, input ready);
  modport sink(input valid, status, woken_task, count_now, waiters_now, output ready);
endinterface

// File: hw/rtl/priority_wait_counting_semaphore.sv
// Top level of the priority wait counting semaphore: APB register, controller, datapath.
//
//   channel  direction  handshake               payload
//   in_ch    in         valid / ready           op, task_id, priority_req
//   out_ch   out        valid / ready           status, woken_task, count_now, waiters_now
//   cfg_*    in         APB setup + access      start count at byte address 0
//
// Each request is transferred in while idle, then the execute step updates the count and
// the sorted queue row and loads the result register. The queue row inserts or pops in
// that one step, one compare per cell.
// A pending result does not block the next transfer in; a request whose result cannot
// yet be loaded holds in the execute step until the result register drains.
// rst_n is synchronous and active low; it clears the count, the queue length and the
// start-count register. No clearing pass is needed.
module priority_wait_counting_semaphore #(
  parameter int MAX_WAITERS   = 16,
  parameter int PRIORITY_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  pwcs_in_if.sink                          in_ch,
  pwcs_out_if.source                       out_ch,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [pwcs_pkg::APB_AW-1:0]      cfg_paddr,
  input  logic [pwcs_pkg::APB_DW-1:0]      cfg_pwdata,
  output logic [pwcs_pkg::APB_DW-1:0]      cfg_prdata,
  output logic                             cfg_pready
);

`include "priority_wait_counting_semaphore_assert.svh"

  pwcs_pkg::dp_cmd_t            cmd;
  pwcs_pkg::dp_stat_t           stat;
  logic                         in_ready;
  logic                         cfg_load;
  logic [pwcs_pkg::CNT_W-1:0]   init_count_r;

  // APB: no wait states; only word 0 decodes to the start-count register.
  assign cfg_pready = 1'b1;
  assign cfg_load   = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_count_r <= '0;
    end else if (cfg_load) begin
      init_count_r <= cfg_pwdata[pwcs_pkg::CNT_W-1:0];
    end
  end

  // Read back the start count; anything above it reads as zero.
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == 1'b0) begin
      cfg_prdata = {{(pwcs_pkg::APB_DW - pwcs_pkg::CNT_W){1'b0}}, init_count_r};
    end
  end

  pwcs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  assign in_ch.ready = in_ready;

  pwcs_dp #(
    .MAX_WAITERS   (MAX_WAITERS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_load        (cfg_load),
    .cfg_count       (cfg_pwdata[pwcs_pkg::CNT_W-1:0]),
    .in_op           (in_ch.op),
    .in_task_id      (in_ch.task_id),
    .in_priority_req (in_ch.priority_req),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_status      (out_ch.status),
    .out_woken_task  (out_ch.woken_task),
    .out_count_now   (out_ch.count_now),
    .out_waiters_now (out_ch.waiters_now)
  );

  // One request in flight: in the cycle after a transfer in, the input is closed.
  `PWCS_ASSERT_NXT(a_one_in_flight, in_ch.valid && in_ready, !in_ready,
    "request accepted while previous one still executing")

  // Tasks only queue while the count is zero.
  `PWCS_ASSERT_IMP(a_queue_implies_zero,
    out_ch.valid && (out_ch.waiters_now != '0), out_ch.count_now == '0,
    "waiters queued with a nonzero count")

  // The woken id is zero unless a waiter was released.
  `PWCS_ASSERT_IMP(a_woken_only_on_wake,
    out_ch.valid && (out_ch.status != pwcs_pkg::STAT_WOKEN), out_ch.woken_task == '0,
    "woken_task set without a released waiter")

endmodule

// File: hw/rtl/pwcs_ctrl.sv
// Controller state machine: sequences capture and commit of one request.
module pwcs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pwcs_pkg::dp_stat_t  stat,
  output pwcs_pkg::dp_cmd_t   cmd
);

  pwcs_pkg::state_t state_r;
  pwcs_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pwcs_pkg::FSM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pwcs_pkg::FSM_IDLE: begin
        if (in_valid) begin
          state_nxt = pwcs_pkg::FSM_EXEC;
        end
      end
      pwcs_pkg::FSM_EXEC: begin
        if (stat.out_free) begin
          state_nxt = pwcs_pkg::FSM_IDLE;
        end
      end
      default: state_nxt = pwcs_pkg::FSM_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    case (state_r)
      pwcs_pkg::FSM_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      pwcs_pkg::FSM_EXEC: begin
        // hold until the result register can take the new result
        cmd.commit = stat.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// File: hw/rtl/pwcs_dp.sv
// Datapath: count, sorted wait-queue cell row and result register.
module pwcs_dp #(
  parameter int MAX_WAITERS   = 16,
  parameter int PRIORITY_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pwcs_pkg::dp_cmd_t                 cmd,
  output pwcs_pkg::dp_stat_t                stat,
  input  logic                              cfg_load,
  input  logic [pwcs_pkg::CNT_W-1:0]        cfg_count,
  input  logic                              in_op,
  input  logic [pwcs_pkg::ID_W-1:0]         in_task_id,
  input  logic [pwcs_pkg::IN_PRIO_W-1:0]    in_priority_req,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pwcs_pkg::STAT_W-1:0]       out_status,
  output logic [pwcs_pkg::ID_W-1:0]         out_woken_task,
  output logic [pwcs_pkg::CNT_W-1:0]        out_count_now,
  output logic [pwcs_pkg::WAIT_W-1:0]       out_waiters_now
);

  localparam int LW = $clog2(MAX_WAITERS + 1);
  localparam int PW = PRIORITY_BITS;

  // Request latch.
  logic                          op_r;
  logic [pwcs_pkg::ID_W-1:0]     id_r;
  logic [PW-1:0]                 prio_r;
  logic [pwcs_pkg::IN_PRIO_W+15:0] prio_wide;

  // Semaphore state.
  logic [pwcs_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [LW-1:0]                 len_r, len_nxt;

  // Queue cells, head at index 0.
  logic [pwcs_pkg::ID_W-1:0]     q_id_r   [MAX_WAITERS];
  logic [PW-1:0]                 q_prio_r [MAX_WAITERS];
  logic [pwcs_pkg::ID_W-1:0]     q_id_nxt   [MAX_WAITERS];
  logic [PW-1:0]                 q_prio_nxt [MAX_WAITERS];
  logic [MAX_WAITERS-1:0]        ge;

  logic                          do_insert, do_pop;
  pwcs_pkg::status_t             status_nxt;
  logic [pwcs_pkg::ID_W-1:0]     woken_nxt;

  // Result register.
  logic                          out_valid_r, out_valid_nxt;
  logic [pwcs_pkg::STAT_W-1:0]   out_status_r;
  logic [pwcs_pkg::ID_W-1:0]     out_woken_r;
  logic [pwcs_pkg::CNT_W-1:0]    out_count_r;
  logic [pwcs_pkg::WAIT_W-1:0]   out_waiters_r;

  assign prio_wide = {16'b0, in_priority_req};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_op;
      id_r   <= in_task_id;
      prio_r <= prio_wide[PW-1:0];
    end
  end

  // Operation decode.
  always_comb begin
    count_nxt  = count_r;
    len_nxt    = len_r;
    do_insert  = 1'b0;
    do_pop     = 1'b0;
    woken_nxt  = '0;
    status_nxt = pwcs_pkg::STAT_GRANTED;
    if (op_r == pwcs_pkg::OP_WAIT) begin
      if (count_r != '0) begin
        count_nxt  = count_r - 1'b1;
        status_nxt = pwcs_pkg::STAT_GRANTED;
      end else if (len_r == LW'(MAX_WAITERS)) begin
        status_nxt = pwcs_pkg::STAT_QUEUE_FULL;
      end else begin
        do_insert  = 1'b1;
        len_nxt    = len_r + 1'b1;
        status_nxt = pwcs_pkg::STAT_BLOCKED;
      end
    end else begin
      if (len_r != '0) begin
        do_pop     = 1'b1;
        woken_nxt  = q_id_r[0];
        len_nxt    = len_r - 1'b1;
        status_nxt = pwcs_pkg::STAT_WOKEN;
      end else if (count_r == pwcs_pkg::CNT_MAX) begin
        status_nxt = pwcs_pkg::STAT_SATURATED;
      end else begin
        count_nxt  = count_r + 1'b1;
        status_nxt = pwcs_pkg::STAT_INCREMENTED;
      end
    end
  end

  // Each occupied cell flags whether it stays ahead of the new entry; the
  // flags form a prefix since the row is kept sorted.
  always_comb begin
    for (int i = 0; i < MAX_WAITERS; i++) begin
      ge[i] = (LW'(i) < len_r) && (q_prio_r[i] >= prio_r);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_WAITERS; i++) begin
      q_id_nxt[i]   = q_id_r[i];
      q_prio_nxt[i] = q_prio_r[i];
      if (do_insert && !ge[i]) begin
        if (i == 0 || ge[(i == 0) ? 0 : i - 1]) begin
          q_id_nxt[i]   = id_r;
          q_prio_nxt[i] = prio_r;
        end else begin
          q_id_nxt[i]   = q_id_r[(i == 0) ? 0 : i - 1];
          q_prio_nxt[i] = q_prio_r[(i == 0) ? 0 : i - 1];
        end
      end else if (do_pop && i < MAX_WAITERS - 1) begin
        q_id_nxt[i]   = q_id_r[(i < MAX_WAITERS - 1) ? i + 1 : i];
        q_prio_nxt[i] = q_prio_r[(i < MAX_WAITERS - 1) ? i + 1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      for (int i = 0; i < MAX_WAITERS; i++) begin
        q_id_r[i]   <= q_id_nxt[i];
        q_prio_r[i] <= q_prio_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      len_r   <= '0;
    end else if (cfg_load) begin
      count_r <= cfg_count;
      len_r   <= '0;
    end else if (cmd.commit) begin
      count_r <= count_nxt;
      len_r   <= len_nxt;
    end
  end

  assign stat.out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r  <= status_nxt;
      out_woken_r   <= woken_nxt;
      out_count_r   <= count_nxt;
      out_waiters_r <= pwcs_pkg::WAIT_W'(len_nxt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_woken_task  = out_woken_r;
  assign out_count_now   = out_count_r;
  assign out_waiters_now = out_waiters_r;

endmodule

// File: test/tb_top.sv
// Testbench for the priority wait counting semaphore: directed and random requests vs a model.
`timescale 1ns / 1ps

module tb_top;

  // Block configuration as built; the model keeps its own copy.
  localparam int SEM_DEPTH      = 16;
  localparam int SEM_PRIO_BITS  = 8;

  // Register map: start count at index 0, index 1 is unmapped.
  localparam int REG_START_COUNT = 0;
  localparam int REG_SPARE       = 1;
  localparam logic [pwcs_pkg::APB_AW-1:0] ADDR_START_COUNT =
    pwcs_pkg::APB_AW'(4 * REG_START_COUNT);
  localparam logic [pwcs_pkg::APB_AW-1:0] ADDR_SPARE =
    pwcs_pkg::APB_AW'(4 * REG_SPARE);

  localparam int RESET_CYCLES  = 8;
  localparam int SETTLE_CYCLES = 6;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int NUM_PHASES    = 10;
  localparam int PHASE_ITEMS   = 115;

  typedef enum int {
    PACE_FULL,
    PACE_SEND_GAPS,
    PACE_RECV_STALLS,
    PACE_BOTH
  } pace_t;

  typedef struct {
    pwcs_pkg::status_t           status;
    logic [pwcs_pkg::ID_W-1:0]   woken;
    logic [pwcs_pkg::CNT_W-1:0]  count;
    logic [pwcs_pkg::WAIT_W-1:0] waiters;
  } sem_result_t;

  // Semaphore model plus the queue of results it still owes.
  class sem_scoreboard;
    sem_result_t                owed_results[$];
    logic [pwcs_pkg::CNT_W-1:0] sem_count;
    logic [pwcs_pkg::ID_W-1:0]  waiter_ids[SEM_DEPTH];
    logic [7:0]                 waiter_prios[SEM_DEPTH];
    int unsigned                waiter_total;
    int unsigned                errors;

    function new();
      sem_count    = '0;
      waiter_total = 0;
      errors       = 0;
    endfunction

    // Register write: reload the count and empty the wait queue.
    function void load_count(logic [pwcs_pkg::CNT_W-1:0] value);
      sem_count    = value;
      waiter_total = 0;
    endfunction

    function void note_request(logic op, logic [pwcs_pkg::ID_W-1:0] id,
                               logic [pwcs_pkg::IN_PRIO_W-1:0] prio_in);
      sem_result_t r;
      logic [7:0]  prio;
      int unsigned slot;
      int unsigned i;
      prio    = prio_in & 8'((1 << SEM_PRIO_BITS) - 1);
      r.woken = '0;
      if (op == pwcs_pkg::OP_WAIT) begin
        if (sem_count != 0) begin
          sem_count = sem_count - 1'b1;
          r.status  = pwcs_pkg::STAT_GRANTED;
        end else if (waiter_total >= SEM_DEPTH) begin
          r.status = pwcs_pkg::STAT_QUEUE_FULL;
        end else begin
          // Land behind every waiter of equal or higher priority.
          slot = 0;
          while (slot < waiter_total && waiter_prios[slot] >= prio) slot++;
          for (i = waiter_total; i > slot; i--) begin
            waiter_ids[i]   = waiter_ids[i-1];
            waiter_prios[i] = waiter_prios[i-1];
          end
          waiter_ids[slot]   = id;
          waiter_prios[slot] = prio;
          waiter_total++;
          r.status = pwcs_pkg::STAT_BLOCKED;
        end
      end else begin
        if (waiter_total > 0) begin
          r.woken = waiter_ids[0];
          for (i = 1; i < waiter_total; i++) begin
            waiter_ids[i-1]   = waiter_ids[i];
            waiter_prios[i-1] = waiter_prios[i];
          end
          waiter_total--;
          r.status = pwcs_pkg::STAT_WOKEN;
        end else if (sem_count == pwcs_pkg::CNT_MAX) begin
          r.status = pwcs_pkg::STAT_SATURATED;
        end else begin
          sem_count = sem_count + 1'b1;
          r.status  = pwcs_pkg::STAT_INCREMENTED;
        end
      end
      r.count   = sem_count;
      r.waiters = pwcs_pkg::WAIT_W'(waiter_total);
      owed_results.push_back(r);
    endfunction

    function void check_result(logic [pwcs_pkg::STAT_W-1:0] status,
                               logic [pwcs_pkg::ID_W-1:0] woken,
                               logic [pwcs_pkg::CNT_W-1:0] count,
                               logic [pwcs_pkg::WAIT_W-1:0] waiters);
      sem_result_t exp;
      if (owed_results.size() == 0) begin
        $error("result with no request outstanding: status %0d", status);
        errors++;
        return;
      end
      exp = owed_results.pop_front();
      if (status !== exp.status) begin
        $error("status mismatch: expected %0d, actual %0d", exp.status, status);
        errors++;
      end
      if (woken !== exp.woken) begin
        $error("woken_task mismatch: expected %0d, actual %0d", exp.woken, woken);
        errors++;
      end
      if (count !== exp.count) begin
        $error("count_now mismatch: expected %0d, actual %0d", exp.count, count);
        errors++;
      end
      if (waiters !== exp.waiters) begin
        $error("waiters_now mismatch: expected %0d, actual %0d", exp.waiters, waiters);
        errors++;
      end
    endfunction
  endclass

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_psel;
  logic                        cfg_penable;
  logic                        cfg_pwrite;
  logic [pwcs_pkg::APB_AW-1:0] cfg_paddr;
  logic [pwcs_pkg::APB_DW-1:0] cfg_pwdata;
  logic [pwcs_pkg::APB_DW-1:0] cfg_prdata;
  logic                        cfg_pready;

  pwcs_in_if  in_ch();
  pwcs_out_if out_ch();

  sem_scoreboard board = new();

  // Idle odds in percent, changed per phase.
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  priority_wait_counting_semaphore DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // 2 ns clock.
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver: pick ready afresh every cycle, off the falling edge.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // One observer for both channels so the order within an edge is fixed:
  // check the result leaving first, then predict for the request coming in.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        board.check_result(out_ch.status, out_ch.woken_task, out_ch.count_now,
                           out_ch.waiters_now);
      if (in_ch.valid && in_ch.ready)
        board.note_request(in_ch.op, in_ch.task_id, in_ch.priority_req);
    end
  end

  function automatic void set_pace(pace_t pace);
    case (pace)
      PACE_FULL: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      PACE_SEND_GAPS: begin
        send_idle_pct  = 77;
        recv_stall_pct = 0;
      end
      PACE_RECV_STALLS: begin
        send_idle_pct  = 0;
        recv_stall_pct = 77;
      end
      default: begin
        send_idle_pct  = 30;
        recv_stall_pct = 30;
      end
    endcase
  endfunction

  // Offer one request; return on the falling edge after its transfer.
  task automatic send_request(logic op, logic [pwcs_pkg::ID_W-1:0] id,
                              logic [pwcs_pkg::IN_PRIO_W-1:0] prio);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid        = 1'b1;
    in_ch.op           = op;
    in_ch.task_id      = id;
    in_ch.priority_req = prio;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // Random request: wait_pct sets the odds of a wait; priorities cluster on a few
  // values half the time so ties (first come, first served) show up often.
  task automatic send_random(int unsigned wait_pct);
    logic                           op;
    logic [pwcs_pkg::IN_PRIO_W-1:0] prio;
    op = ($urandom_range(99) < wait_pct) ? pwcs_pkg::OP_WAIT : pwcs_pkg::OP_SIGNAL;
    case ($urandom_range(3))
      0:       prio = $urandom_range(1) ? 8'hFF : 8'h00;
      1:       prio = 8'd100 + 8'($urandom_range(3));
      default: prio = 8'($urandom_range(255));
    endcase
    send_request(op, 4'($urandom_range(15)), prio);
  endtask

  // Hold the sender until every owed result is out, then let the block settle.
  task automatic drain_results();
    in_ch.valid = 1'b0;
    while (board.owed_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(logic [pwcs_pkg::APB_AW-1:0] addr,
                           logic [pwcs_pkg::APB_DW-1:0] data);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = addr;
    cfg_pwdata  = data;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == ADDR_START_COUNT) board.load_count(data[pwcs_pkg::CNT_W-1:0]);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  // Read the start count back and compare with what was last written.
  task automatic cfg_readback(logic [pwcs_pkg::CNT_W-1:0] written);
    logic [pwcs_pkg::APB_DW-1:0] data;
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = ADDR_START_COUNT;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    data = cfg_prdata;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    if (data !== pwcs_pkg::APB_DW'(written)) begin
      $error("start count readback mismatch: expected %0d, actual %0d", written, data);
      board.errors++;
    end
  endtask

  // Reload the count between phases, only once the block has gone quiet.
  task automatic set_start_count(logic [pwcs_pkg::CNT_W-1:0] value);
    drain_results();
    cfg_write(ADDR_START_COUNT, pwcs_pkg::APB_DW'(value));
    cfg_readback(value);
  endtask

  initial begin
    logic [pwcs_pkg::CNT_W-1:0] phase_counts[NUM_PHASES];
    int unsigned                phase_wait_pct[NUM_PHASES];
    int                         i;
    int                         p;
    int                         waited;

    phase_counts   = '{8'd0, 8'd255, 8'd0, 8'd254, 8'd1, 8'd128, 8'd0, 8'd255, 8'd3, 8'd0};
    phase_wait_pct = '{70, 25, 85, 40, 60, 50, 75, 30, 65, 55};

    // Drive every input to a known value before the first edge.
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.op           = pwcs_pkg::OP_WAIT;
    in_ch.task_id      = '0;
    in_ch.priority_req = '0;
    out_ch.ready       = 1'b0;
    cfg_psel           = 1'b0;
    cfg_penable        = 1'b0;
    cfg_pwrite         = 1'b0;
    cfg_paddr          = '0;
    cfg_pwdata         = '0;
    set_pace(PACE_FULL);

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Register comes out of reset at zero.
    cfg_readback(8'd0);

    // Directed: count from zero, take it back, then fill the queue.
    send_request(pwcs_pkg::OP_SIGNAL, 4'd9, 8'd33);    // count incremented
    send_request(pwcs_pkg::OP_WAIT, 4'd3, 8'd7);       // granted, count back to zero
    for (i = 0; i < SEM_DEPTH; i++) begin
      // Priorities cycle 255, 0, 128; task 15 goes in twice at 255 (duplicate id).
      send_request(pwcs_pkg::OP_WAIT, (i == 3) ? 4'd15 : 4'(i),
                   (i % 3 == 0) ? 8'd255 : ((i % 3 == 1) ? 8'd0 : 8'd128));
    end
    send_request(pwcs_pkg::OP_WAIT, 4'd7, 8'd200);     // queue full, nothing changes
    send_request(pwcs_pkg::OP_SIGNAL, 4'd0, 8'd0);     // wakes task 0, first at 255
    send_request(pwcs_pkg::OP_SIGNAL, 4'd15, 8'd255);  // wakes task 15, next at 255

    // Reload while waiters remain: the queue must empty. The spare index must not stick.
    drain_results();
    cfg_write(ADDR_START_COUNT, pwcs_pkg::APB_DW'(8'd255));
    cfg_write(ADDR_SPARE, pwcs_pkg::APB_DW'(32'h0000_0007));
    cfg_readback(8'd255);
    send_request(pwcs_pkg::OP_SIGNAL, 4'd1, 8'd1);     // count saturated at 255
    send_request(pwcs_pkg::OP_WAIT, 4'd2, 8'd2);       // granted, 254
    send_request(pwcs_pkg::OP_SIGNAL, 4'd4, 8'd4);     // incremented back to 255

    // Random phases: each reloads the count, picks a mix of waits and signals,
    // and rotates through the idle patterns.
    for (p = 0; p < NUM_PHASES; p++) begin
      set_start_count(phase_counts[p]);
      set_pace(pace_t'(p % 4));
      for (i = 0; i < PHASE_ITEMS; i++) begin
        // Halfway through, hold the sender until the block has caught up.
        if (i == PHASE_ITEMS / 2) drain_results();
        send_random(phase_wait_pct[p]);
      end
    end

    // Wait out the last results, with a bound, then give the block time to
    // show anything stray.
    in_ch.valid = 1'b0;
    waited = 0;
    while (board.owed_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (board.owed_results.size() != 0) begin
      $error("%0d results never arrived", board.owed_results.size());
      board.errors++;
    end

    if (board.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
